>>> sv/stg_pkg.sv
`default_nettype none

package stg_pkg;

    // field and register widths
    localparam int FREQ_W   = 17;
    localparam int RATE_W   = 18;
    localparam int VOL_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 23;

    localparam int INDEX_WRAP = 4800000;
    localparam int ANGLE_BITS = 16;

    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1000);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    // configuration port
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_FREQ = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_RATE = REG_IDX_W'(1);

    // stream payloads
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // serial divider: residue plus frequency needs one bit more than the rate
    localparam int DIV_W  = RATE_W + 1;
    localparam int QUOT_W = (ANGLE_BITS > DIV_W) ? ANGLE_BITS : DIV_W;
    localparam int DCNT_W = $clog2(QUOT_W + 1);

    // cordic
    localparam int TURN_W       = 32;
    localparam int CORDIC_W     = 33;
    localparam int CORDIC_STEPS = 24;
    localparam int CSTEP_W      = $clog2(CORDIC_STEPS);
    localparam logic [CORDIC_W-1:0] CORDIC_X0    = CORDIC_W'(652032874);
    localparam logic [TURN_W-1:0]   TURN_QUARTER = 32'h4000_0000;
    localparam logic [TURN_W-1:0]   TURN_HALF    = 32'h8000_0000;

    // scaling
    localparam int PROD_W   = VOL_W + CORDIC_W;
    localparam int FRAC_W   = 30;
    localparam int SCALED_W = PROD_W - FRAC_W;
    localparam int SCNT_W   = $clog2(VOL_W + 1);
    localparam logic [SCALED_W-1:0] SCALED_MAX = SCALED_W'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic [SCALED_W-1:0] SCALED_MIN = SCALED_W'(-(2 ** (SAMPLE_W - 1) - 1));

    typedef struct packed {
        logic                start;
        logic [RATE_W-1:0]   rem_init;
        logic [DIV_W-1:0]    dividend;
        logic [DCNT_W-1:0]   steps;
    } div_cmd_t;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quot;
        logic [RATE_W-1:0]   rem;
    } div_rsp_t;

    typedef struct packed {
        logic                  start;
        logic [ANGLE_BITS-1:0] angle;
    } cor_cmd_t;

    typedef struct packed {
        logic                done;
        logic [CORDIC_W-1:0] y;
    } cor_rsp_t;

    typedef struct packed {
        logic                start;
        logic [VOL_W-1:0]    vol;
        logic [CORDIC_W-1:0] y;
    } scl_cmd_t;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] sample;
    } scl_rsp_t;

    // arctangent of 2^-i in 2^32-per-turn units
    function automatic logic [CORDIC_W-1:0] atan_turn(input logic [CSTEP_W-1:0] idx);
        logic [CORDIC_W-1:0] val;
        case (idx)
            CSTEP_W'(0):  val = CORDIC_W'(536870912);
            CSTEP_W'(1):  val = CORDIC_W'(316933406);
            CSTEP_W'(2):  val = CORDIC_W'(167458907);
            CSTEP_W'(3):  val = CORDIC_W'(85004756);
            CSTEP_W'(4):  val = CORDIC_W'(42667331);
            CSTEP_W'(5):  val = CORDIC_W'(21354465);
            CSTEP_W'(6):  val = CORDIC_W'(10679838);
            CSTEP_W'(7):  val = CORDIC_W'(5340245);
            CSTEP_W'(8):  val = CORDIC_W'(2670163);
            CSTEP_W'(9):  val = CORDIC_W'(1335087);
            CSTEP_W'(10): val = CORDIC_W'(667544);
            CSTEP_W'(11): val = CORDIC_W'(333772);
            CSTEP_W'(12): val = CORDIC_W'(166886);
            CSTEP_W'(13): val = CORDIC_W'(83443);
            CSTEP_W'(14): val = CORDIC_W'(41722);
            CSTEP_W'(15): val = CORDIC_W'(20861);
            CSTEP_W'(16): val = CORDIC_W'(10430);
            CSTEP_W'(17): val = CORDIC_W'(5215);
            CSTEP_W'(18): val = CORDIC_W'(2608);
            CSTEP_W'(19): val = CORDIC_W'(1304);
            CSTEP_W'(20): val = CORDIC_W'(652);
            CSTEP_W'(21): val = CORDIC_W'(326);
            CSTEP_W'(22): val = CORDIC_W'(163);
            CSTEP_W'(23): val = CORDIC_W'(81);
            default:      val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> sv/stg_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module stg_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire stg_pkg::div_cmd_t         cmd,
    input  wire logic [stg_pkg::RATE_W-1:0] divisor,
    output stg_pkg::div_rsp_t              rsp
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [stg_pkg::DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [stg_pkg::RATE_W-1:0]   rem_reg, rem_next;
    logic [stg_pkg::DIV_W-1:0]    dvd_reg, dvd_next;
    logic [stg_pkg::QUOT_W-1:0]   quot_reg, quot_next;
    logic [stg_pkg::RATE_W:0]     trial;
    logic [stg_pkg::RATE_W:0]     diff;
    logic                         ge;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[stg_pkg::DIV_W-1]};
        diff  = trial - {1'b0, divisor};
        ge    = trial >= {1'b0, divisor};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
            rem_next  = cmd.rem_init;
            dvd_next  = cmd.dividend;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[stg_pkg::RATE_W-1:0] : trial[stg_pkg::RATE_W-1:0];
            dvd_next  = {dvd_reg[stg_pkg::DIV_W-2:0], 1'b0};
            quot_next = {quot_reg[stg_pkg::QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - stg_pkg::DCNT_W'(1);
            if (cnt_reg == stg_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

>>> sv/stg_cordic.sv
`default_nettype none

// rotation-mode cordic, one micro-rotation per cycle
module stg_cordic (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stg_pkg::cor_cmd_t cmd,
    output stg_pkg::cor_rsp_t      rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [stg_pkg::CSTEP_W-1:0]   step_reg, step_next;
    logic signed [stg_pkg::CORDIC_W-1:0] x_reg, x_next;
    logic signed [stg_pkg::CORDIC_W-1:0] y_reg, y_next;
    logic signed [stg_pkg::CORDIC_W-1:0] z_reg, z_next;
    logic signed [stg_pkg::CORDIC_W-1:0] x_sh, y_sh, at;
    logic [stg_pkg::TURN_W-1:0]    turn, turn_off, folded;
    logic                          dir;

    always_comb
    begin
        // fold into [-1/4, 1/4] turn using sin(t) = sin(1/2 - t)
        turn     = {cmd.angle, {(stg_pkg::TURN_W - stg_pkg::ANGLE_BITS){1'b0}}};
        turn_off = turn - stg_pkg::TURN_QUARTER;
        folded   = (turn_off < stg_pkg::TURN_HALF) ? (stg_pkg::TURN_HALF - turn) : turn;

        x_sh = x_reg >>> step_reg;
        y_sh = y_reg >>> step_reg;
        at   = $signed(stg_pkg::atan_turn(step_reg));
        dir  = ~z_reg[stg_pkg::CORDIC_W-1];

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            x_next    = $signed(stg_pkg::CORDIC_X0);
            y_next    = '0;
            z_next    = $signed({{(stg_pkg::CORDIC_W - stg_pkg::TURN_W){folded[stg_pkg::TURN_W-1]}},
                                 folded});
        end
        else if (busy_reg)
        begin
            x_next    = dir ? (x_reg - y_sh) : (x_reg + y_sh);
            y_next    = dir ? (y_reg + x_sh) : (y_reg - x_sh);
            z_next    = dir ? (z_reg - at) : (z_reg + at);
            step_next = step_reg + stg_pkg::CSTEP_W'(1);
            if (step_reg == stg_pkg::CSTEP_W'(stg_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign rsp.done = done_reg;
    assign rsp.y    = y_reg;

endmodule

`default_nettype wire

>>> sv/stg_scale.sv
`default_nettype none

// shift-add volume multiply, one volume bit per cycle, then round and saturate
module stg_scale (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stg_pkg::scl_cmd_t cmd,
    output stg_pkg::scl_rsp_t      rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [stg_pkg::SCNT_W-1:0]        cnt_reg, cnt_next;
    logic [stg_pkg::VOL_W-1:0]         vol_reg, vol_next;
    logic [stg_pkg::CORDIC_W-1:0]      y_reg, y_next;
    logic signed [stg_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [stg_pkg::SAMPLE_W-1:0]      sample_reg, sample_next;
    logic signed [stg_pkg::PROD_W-1:0] addend, rnd;
    logic signed [stg_pkg::SCALED_W-1:0] scaled;

    always_comb
    begin
        addend = vol_reg[stg_pkg::VOL_W-1]
               ? $signed({{(stg_pkg::PROD_W - stg_pkg::CORDIC_W){y_reg[stg_pkg::CORDIC_W-1]}}, y_reg})
               : '0;
        rnd    = acc_reg + $signed(stg_pkg::PROD_W'(1) << (stg_pkg::FRAC_W - 1));
        scaled = rnd[stg_pkg::PROD_W-1:stg_pkg::FRAC_W];

        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        vol_next    = vol_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        sample_next = sample_reg;

        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = stg_pkg::SCNT_W'(stg_pkg::VOL_W);
            vol_next  = cmd.vol;
            y_next    = cmd.y;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                acc_next = (acc_reg <<< 1) + addend;
                vol_next = {vol_reg[stg_pkg::VOL_W-2:0], 1'b0};
                cnt_next = cnt_reg - stg_pkg::SCNT_W'(1);
            end
            else
            begin
                if (scaled > $signed(stg_pkg::SCALED_MAX))
                    sample_next = stg_pkg::SCALED_MAX[stg_pkg::SAMPLE_W-1:0];
                else if (scaled < $signed(stg_pkg::SCALED_MIN))
                    sample_next = stg_pkg::SCALED_MIN[stg_pkg::SAMPLE_W-1:0];
                else
                    sample_next = scaled[stg_pkg::SAMPLE_W-1:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vol_reg    <= vol_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        sample_reg <= sample_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.sample = sample_reg;

endmodule

`default_nettype wire

>>> sv/sine_tone_generator.sv
`default_nettype none

// channel    | dir | signals                        | content
// -----------+-----+--------------------------------+-------------------------------
// s_axis     | in  | tvalid, tready, tdata[15:0]    | volume, Q0.15 unsigned
// m_axis     | out | tvalid, tready, tdata[15:0]    | sample, Q1.15 signed
// apb        | in  | psel, penable, pwrite, paddr,  | 0x0 tone_frequency (Hz),
//            |     | pwdata, prdata, pready         | 0x4 sample_rate (Hz)
//
// one item at a time; between one input transfer and the next the item goes through
// two passes of the bit-serial divider (residue mod rate, then the 16-bit phase angle),
// then 24 cordic iterations overlapped with the residue-update division, then a
// bit-serial shift-add volume multiply with a round/saturate step
// a finished sample sits in the output register; the next input is taken meanwhile,
// the pipeline only waits if its new sample is ready while the old one is still unread
// reset (rst_n, async, active low) restores 1000 Hz / 48000 Hz and zeroes index and phase
module sine_tone_generator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [stg_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [stg_pkg::PDATA_W-1:0]    pwdata,
    output logic      [stg_pkg::PDATA_W-1:0]    prdata,
    output logic                                pready,
    // input stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [stg_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [14:0] volume
    // output stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [stg_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [15:0] sample
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,   // waiting for a volume transfer
        ST_MOD  = 6'b000010,   // residue mod rate
        ST_ANG  = 6'b000100,   // residue * 2^16 / rate
        ST_ROT  = 6'b001000,   // cordic, residue update in the divider
        ST_SCL  = 6'b010000,   // volume multiply
        ST_WAIT = 6'b100000    // hand sample to the output register
    } state_t;

    state_t                          state_reg, state_next;
    logic [stg_pkg::FREQ_W-1:0]      freq_reg, freq_next;
    logic [stg_pkg::RATE_W-1:0]      rate_reg, rate_next;
    logic [stg_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [stg_pkg::RATE_W-1:0]      residue_reg, residue_next;
    logic [stg_pkg::RATE_W-1:0]      r_reg, r_next;       // reduced residue of this item
    logic [stg_pkg::RATE_W-1:0]      upd_reg, upd_next;   // residue for the next item
    logic [stg_pkg::VOL_W-1:0]       vol_reg, vol_next;
    logic                            out_valid_reg, out_valid_next;
    logic [stg_pkg::SAMPLE_W-1:0]    out_data_reg, out_data_next;

    stg_pkg::div_cmd_t               div_cmd;
    stg_pkg::div_rsp_t               div_rsp;
    stg_pkg::cor_cmd_t               cor_cmd;
    stg_pkg::cor_rsp_t               cor_rsp;
    stg_pkg::scl_cmd_t               scl_cmd;
    stg_pkg::scl_rsp_t               scl_rsp;

    logic                            wr_en;
    logic [stg_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                            rate_zero;
    logic [stg_pkg::RATE_W:0]        rnd_sum;
    logic                            rnd_up;
    logic [stg_pkg::ANGLE_BITS-1:0]  angle;

    stg_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (div_cmd),
        .divisor (rate_reg),
        .rsp     (div_rsp)
    );

    stg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cor_cmd),
        .rsp   (cor_rsp)
    );

    stg_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scl_cmd),
        .rsp   (scl_rsp)
    );

    // register file: address bit 2 picks the register, low bits are ignored
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[stg_pkg::ADDR_W-1:2];

    always_comb
    begin
        unique case (reg_idx)
            stg_pkg::REG_FREQ: prdata = stg_pkg::PDATA_W'(freq_reg);
            stg_pkg::REG_RATE: prdata = stg_pkg::PDATA_W'(rate_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        freq_next = freq_reg;
        rate_next = rate_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                stg_pkg::REG_FREQ: freq_next = pwdata[stg_pkg::FREQ_W-1:0];
                stg_pkg::REG_RATE: rate_next = pwdata[stg_pkg::RATE_W-1:0];
                default:           ;
            endcase
        end
    end

    // phase angle rounding: remainder of the 16-step division plus half the rate
    always_comb
    begin
        rate_zero = (rate_reg == '0);
        rnd_sum   = {1'b0, div_rsp.rem} + {2'b0, rate_reg[stg_pkg::RATE_W-1:1]};
        rnd_up    = (rnd_sum >= {1'b0, rate_reg});
        angle     = rate_zero ? '0
                  : div_rsp.quot[stg_pkg::ANGLE_BITS-1:0] + stg_pkg::ANGLE_BITS'(rnd_up);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        residue_next   = residue_reg;
        r_next         = r_reg;
        upd_next       = upd_reg;
        vol_next       = vol_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;

        div_cmd = '0;
        cor_cmd = '0;
        scl_cmd = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    vol_next         = s_axis_tdata[stg_pkg::VOL_W-1:0];
                    div_cmd.start    = 1'b1;
                    div_cmd.rem_init = '0;
                    div_cmd.dividend = stg_pkg::DIV_W'(residue_reg);
                    div_cmd.steps    = stg_pkg::DCNT_W'(stg_pkg::DIV_W);
                    state_next       = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    r_next           = rate_zero ? '0 : div_rsp.rem;
                    div_cmd.start    = 1'b1;
                    div_cmd.rem_init = div_rsp.rem;
                    div_cmd.dividend = '0;
                    div_cmd.steps    = stg_pkg::DCNT_W'(stg_pkg::ANGLE_BITS);
                    state_next       = ST_ANG;
                end
            end
            ST_ANG:
            begin
                if (div_rsp.done)
                begin
                    cor_cmd.start    = 1'b1;
                    cor_cmd.angle    = angle;
                    div_cmd.start    = 1'b1;
                    div_cmd.rem_init = '0;
                    div_cmd.dividend = {1'b0, r_reg} + stg_pkg::DIV_W'(freq_reg);
                    div_cmd.steps    = stg_pkg::DCNT_W'(stg_pkg::DIV_W);
                    state_next       = ST_ROT;
                end
            end
            ST_ROT:
            begin
                // the update division ends well before the last micro-rotation
                if (div_rsp.done)
                    upd_next = rate_zero ? '0 : div_rsp.rem;
                if (cor_rsp.done)
                begin
                    scl_cmd.start = 1'b1;
                    scl_cmd.vol   = vol_reg;
                    scl_cmd.y     = cor_rsp.y;
                    state_next    = ST_SCL;
                end
            end
            ST_SCL:
            begin
                if (scl_rsp.done)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = scl_rsp.sample;
                    out_valid_next = 1'b1;
                    if (count_reg >= stg_pkg::COUNT_W'(stg_pkg::INDEX_WRAP))
                    begin
                        count_next   = '0;
                        residue_next = '0;
                    end
                    else
                    begin
                        count_next   = count_reg + stg_pkg::COUNT_W'(1);
                        residue_next = upd_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            freq_reg      <= stg_pkg::FREQ_RESET;
            rate_reg      <= stg_pkg::RATE_RESET;
            count_reg     <= '0;
            residue_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            freq_reg      <= freq_next;
            rate_reg      <= rate_next;
            count_reg     <= count_next;
            residue_reg   <= residue_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        upd_reg      <= upd_next;
        vol_reg      <= vol_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> sv/stg_props.sv
`default_nettype none

module stg_props (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [stg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // saturation keeps the sample symmetric
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != 16'h8000)
        else $error("sample outside +-32767");

    // an accepted volume keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transfer taken while an item is in flight");

    // no sample can appear right after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result produced too early");

endmodule

bind sine_tone_generator stg_props u_props (.*);

`default_nettype wire
